### design/msg_pkg.sv
package msg_pkg;

  localparam int unsigned MaxStops = 8;
  localparam int unsigned IdxW     = $clog2(MaxStops);
  localparam int unsigned CntW     = 4;
  localparam int unsigned PosW     = 32;
  localparam int unsigned ColW     = 32;
  localparam int unsigned DivW     = 33;
  localparam int unsigned WgtW     = 17;
  localparam int unsigned QDepth   = 2;

  typedef enum logic [1:0] {
    KIND_EMPTY  = 2'd0,
    KIND_SOLID  = 2'd1,
    KIND_BLEND  = 2'd2
  } kind_e;

  // one classified lookup handed from front to back
  typedef struct packed {
    kind_e                kind;
    logic [ColW-1:0]      left_col;
    logic [ColW-1:0]      right_col;
    logic [DivW-1:0]      offset;
    logic [DivW-1:0]      span;
  } job_t;

endpackage

### design/msg_front.sv
module msg_front (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic [msg_pkg::CntW-1:0]  stop_count_i,
  input  logic                      in_valid_i,
  output logic                      in_ready_o,
  input  logic                      mode_i,
  input  logic [msg_pkg::IdxW-1:0]  stop_index_i,
  input  logic signed [31:0]        position_i,
  input  logic [31:0]               color_i,
  output logic                      job_valid_o,
  input  logic                      job_ready_i,
  output msg_pkg::job_t             job_o
);

  typedef enum logic [1:0] {
    ST_IDLE = 2'd0,
    ST_SCAN = 2'd1,
    ST_SEND = 2'd2
  } state_e;

  localparam int unsigned CntMax = msg_pkg::MaxStops;

  // stop table in flip-flops, one read port chosen by the scan index
  logic [msg_pkg::PosW-1:0] pos_mem [msg_pkg::MaxStops];
  logic [msg_pkg::ColW-1:0] col_mem [msg_pkg::MaxStops];

  state_e                    state_q;
  logic [msg_pkg::CntW:0]    idx_q;
  logic [msg_pkg::CntW:0]    n_q;
  logic signed [31:0]        look_q;
  logic signed [31:0]        prev_pos_q;
  logic [msg_pkg::ColW-1:0]  prev_col_q;
  msg_pkg::job_t             job_q;

  logic [msg_pkg::IdxW-1:0]  rd_idx;
  logic signed [31:0]        rd_pos;
  logic [msg_pkg::ColW-1:0]  rd_col;
  logic [msg_pkg::CntW:0]    n_d;

  assign rd_idx = idx_q[msg_pkg::IdxW-1:0];
  assign rd_pos = pos_mem[rd_idx];
  assign rd_col = col_mem[rd_idx];
  assign n_d    = ({1'b0, stop_count_i} > (msg_pkg::CntW+1)'(CntMax)) ?
                  (msg_pkg::CntW+1)'(CntMax) : {1'b0, stop_count_i};

  assign in_ready_o  = (state_q == ST_IDLE);
  assign job_valid_o = (state_q == ST_SEND);
  assign job_o       = job_q;

  // table writes
  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o && !mode_i) begin
      pos_mem[stop_index_i] <= position_i;
      col_mem[stop_index_i] <= color_i;
    end
  end

  // segment search, one stop a cycle
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      idx_q   <= '0;
    end else begin
      unique case (state_q)
        ST_IDLE: begin
          if (in_valid_i && mode_i) begin
            look_q <= position_i;
            n_q    <= n_d;
            idx_q  <= '0;
            if (n_d == '0) begin
              job_q.kind <= msg_pkg::KIND_EMPTY;
              state_q    <= ST_SEND;
            end else begin
              state_q <= ST_SCAN;
            end
          end
        end
        ST_SCAN: begin
          if (idx_q == '0) begin
            if (look_q <= rd_pos) begin
              job_q.kind     <= msg_pkg::KIND_SOLID;
              job_q.left_col <= rd_col;
              state_q        <= ST_SEND;
            end
          end else if (look_q <= rd_pos) begin
            job_q.kind      <= msg_pkg::KIND_BLEND;
            job_q.left_col  <= prev_col_q;
            job_q.right_col <= rd_col;
            job_q.offset    <= DivW_sub(look_q, prev_pos_q);
            job_q.span      <= DivW_sub(rd_pos, prev_pos_q);
            state_q         <= ST_SEND;
          end
          if (!(look_q <= rd_pos)) begin
            if (idx_q + 1'b1 == n_q) begin
              job_q.kind     <= msg_pkg::KIND_SOLID;
              job_q.left_col <= rd_col;
              state_q        <= ST_SEND;
            end
          end
          prev_pos_q <= rd_pos;
          prev_col_q <= rd_col;
          idx_q      <= idx_q + 1'b1;
        end
        ST_SEND: begin
          if (job_ready_i) state_q <= ST_IDLE;
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  function automatic logic [msg_pkg::DivW-1:0] DivW_sub(logic signed [31:0] a,
                                                       logic signed [31:0] b);
    logic signed [msg_pkg::DivW-1:0] r;
    r = {a[31], a} - {b[31], b};
    return r;
  endfunction

endmodule

### design/msg_queue.sv
module msg_queue (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          wr_valid_i,
  output logic          wr_ready_o,
  input  msg_pkg::job_t wr_data_i,
  output logic          rd_valid_o,
  input  logic          rd_ready_i,
  output msg_pkg::job_t rd_data_o
);

  localparam int unsigned PtrW = $clog2(msg_pkg::QDepth);

  msg_pkg::job_t       mem_q [msg_pkg::QDepth];
  logic [PtrW-1:0]     wp_q, rp_q;
  logic [PtrW:0]       cnt_q;
  logic                push, pop;

  assign wr_ready_o = (cnt_q != (PtrW+1)'(msg_pkg::QDepth));
  assign rd_valid_o = (cnt_q != '0);
  assign rd_data_o  = mem_q[rp_q];
  assign push       = wr_valid_i && wr_ready_o;
  assign pop        = rd_valid_o && rd_ready_i;

  // storage
  always_ff @(posedge clk_i) begin
    if (push) mem_q[wp_q] <= wr_data_i;
  end

  // pointers and fill
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q  <= '0;
      rp_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push) wp_q <= wp_q + 1'b1;
      if (pop)  rp_q <= rp_q + 1'b1;
      cnt_q <= cnt_q + (PtrW+1)'(push) - (PtrW+1)'(pop);
    end
  end

endmodule

### design/msg_back.sv
module msg_back (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          job_valid_i,
  output logic          job_ready_o,
  input  msg_pkg::job_t job_i,
  output logic          out_valid_o,
  input  logic          out_ready_i,
  output logic [7:0]    out_alpha_o,
  output logic [7:0]    out_red_o,
  output logic [7:0]    out_green_o,
  output logic [7:0]    out_blue_o
);

  typedef enum logic [2:0] {
    ST_IDLE = 3'd0,
    ST_DIV  = 3'd1,
    ST_MIX  = 3'd2,
    ST_OUT  = 3'd3
  } state_e;

  localparam int unsigned Steps = msg_pkg::WgtW;
  localparam int unsigned StW   = $clog2(msg_pkg::DivW + 16);

  state_e                     state_q;
  logic [StW-1:0]             step_q;
  logic [msg_pkg::DivW:0]     rem_q;
  logic [msg_pkg::DivW-1:0]   span_q;
  logic [msg_pkg::DivW-1:0]   off_q;
  logic [msg_pkg::WgtW-1:0]   quo_q;
  logic [msg_pkg::ColW-1:0]   lc_q, rc_q;
  logic [1:0]                 ch_q;
  logic [7:0]                 res_q [4];

  logic [msg_pkg::DivW:0]     rem_sh;
  logic                       fits;
  logic [msg_pkg::WgtW-1:0]   w, iw;
  logic [7:0]                 lch, rch;
  logic [msg_pkg::WgtW+8-1:0] mix;

  // restoring division, one quotient bit a cycle: w = off*65536 / span
  assign rem_sh = {rem_q[msg_pkg::DivW-1:0], off_q[msg_pkg::DivW-1]};
  assign fits   = rem_sh >= {1'b0, span_q};

  // one channel a cycle
  assign w   = quo_q;
  assign iw  = msg_pkg::WgtW'(17'h10000) - w;
  assign lch = lc_q[8*(3-ch_q) +: 8];
  assign rch = rc_q[8*(3-ch_q) +: 8];
  assign mix = (msg_pkg::WgtW+8)'(lch) * (msg_pkg::WgtW+8)'(iw)
             + (msg_pkg::WgtW+8)'(rch) * (msg_pkg::WgtW+8)'(w);

  assign job_ready_o = (state_q == ST_IDLE);
  assign out_valid_o = (state_q == ST_OUT);
  assign out_alpha_o = res_q[0];
  assign out_red_o   = res_q[1];
  assign out_green_o = res_q[2];
  assign out_blue_o  = res_q[3];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      step_q  <= '0;
      ch_q    <= '0;
    end else begin
      unique case (state_q)
        ST_IDLE: begin
          if (job_valid_i) begin
            lc_q <= job_i.left_col;
            rc_q <= job_i.right_col;
            unique case (job_i.kind)
              msg_pkg::KIND_EMPTY: begin
                res_q[0] <= 8'd255;
                res_q[1] <= '0;
                res_q[2] <= '0;
                res_q[3] <= '0;
                state_q  <= ST_OUT;
              end
              msg_pkg::KIND_SOLID: begin
                res_q[0] <= job_i.left_col[31:24];
                res_q[1] <= job_i.left_col[23:16];
                res_q[2] <= job_i.left_col[15:8];
                res_q[3] <= job_i.left_col[7:0];
                state_q  <= ST_OUT;
              end
              default: begin
                // off <= span, so dividend off<<16 gives 17 quotient bits;
                // remainder starts at zero, the last 17 of 49 steps give them
                rem_q   <= '0;
                off_q   <= job_i.offset;
                span_q  <= job_i.span;
                quo_q   <= '0;
                step_q  <= '0;
                state_q <= ST_DIV;
              end
            endcase
          end
        end
        ST_DIV: begin
          // shift dividend (off followed by 16 zero bits) through the remainder
          rem_q  <= fits ? (rem_sh - {1'b0, span_q}) : rem_sh;
          off_q  <= {off_q[msg_pkg::DivW-2:0], 1'b0};
          if (step_q >= StW'(msg_pkg::DivW + 16 - Steps)) begin
            quo_q <= {quo_q[msg_pkg::WgtW-2:0], fits};
          end
          step_q <= step_q + 1'b1;
          if (step_q == StW'(msg_pkg::DivW + 16 - 1)) begin
            ch_q    <= '0;
            state_q <= ST_MIX;
          end
        end
        ST_MIX: begin
          res_q[ch_q] <= mix[16 +: 8];
          ch_q        <= ch_q + 1'b1;
          if (ch_q == 2'd3) state_q <= ST_OUT;
        end
        ST_OUT: begin
          if (out_ready_i) state_q <= ST_IDLE;
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

endmodule

### design/multi_stop_gradient_color_lookup_unit.sv
// channel | direction | handshake               | payload
// in      | in        | in_valid_i / in_ready_o | mode, stop_index, position, stop colour
// out     | out       | out_valid_o/out_ready_i | out_alpha/red/green/blue
// cfg     | in        | cfg_we_i                | cfg_wdata_i (stop_count)
// a write word updates the stop table in the front part
// a lookup scans up to 8 stops, one stop a cycle; a blend then takes a bit-serial
// divide and channel blending in the back part (one channel a cycle)
// a two-entry queue between front and back lets the scan of the next word run
// while the back part divides; reset is asynchronous and clears all control state
module multi_stop_gradient_color_lookup_unit (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic [3:0]         cfg_wdata_i,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic               mode_i,
  input  logic [2:0]         stop_index_i,
  input  logic signed [31:0] position_i,
  input  logic [7:0]         stop_alpha_i,
  input  logic [7:0]         stop_red_i,
  input  logic [7:0]         stop_green_i,
  input  logic [7:0]         stop_blue_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic [7:0]         out_alpha_o,
  output logic [7:0]         out_red_o,
  output logic [7:0]         out_green_o,
  output logic [7:0]         out_blue_o
);

  logic [msg_pkg::CntW-1:0] count_q;
  logic                     fj_valid, fj_ready, bj_valid, bj_ready;
  msg_pkg::job_t            fj, bj;

  // stop count register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) count_q <= '0;
    else if (cfg_we_i) count_q <= cfg_wdata_i;
  end

  msg_front u_front (
    .clk_i, .rst_ni,
    .stop_count_i (count_q),
    .in_valid_i, .in_ready_o,
    .mode_i,
    .stop_index_i,
    .position_i,
    .color_i      ({stop_alpha_i, stop_red_i, stop_green_i, stop_blue_i}),
    .job_valid_o  (fj_valid),
    .job_ready_i  (fj_ready),
    .job_o        (fj)
  );

  msg_queue u_queue (
    .clk_i, .rst_ni,
    .wr_valid_i (fj_valid), .wr_ready_o (fj_ready), .wr_data_i (fj),
    .rd_valid_o (bj_valid), .rd_ready_i (bj_ready), .rd_data_o (bj)
  );

  msg_back u_back (
    .clk_i, .rst_ni,
    .job_valid_i (bj_valid), .job_ready_o (bj_ready), .job_i (bj),
    .out_valid_o, .out_ready_i,
    .out_alpha_o, .out_red_o, .out_green_o, .out_blue_o
  );

  // a word stalled at the output stays valid and holds its alpha and blue
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_alpha_o)
      && $stable(out_blue_o))
    else $error("result changed while stalled");

  // back part takes no job while a result waits
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> !bj_ready)
    else $error("back part accepted a job while busy");

  // front offers no job while accepting input
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_ready_o |-> !fj_valid)
    else $error("front part overlap");

endmodule
